/* rtl/dacc_pkg.sv */
package dacc_pkg;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [6:0]  opcode;
		logic [7:0]  operand_char_a;
		logic [7:0]  operand_char_b;
		logic [7:0]  operand_char_c;
		logic [7:0]  operand_char_d;
		logic [9:0]  host_address;
		logic [13:0] host_data;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [6:0]  program_counter;
		logic [13:0] accumulator;
		logic        compare_true;
		logic        range_violation;
		logic [13:0] read_word;
		logic        trap_raised;
		logic [13:0] trap_number;
		logic [3:0]  trap_operation;
	} out_item_t;

	localparam logic [1:0] CMD_EXEC  = 2'd0;
	localparam logic [1:0] CMD_HWR   = 2'd1;
	localparam logic [1:0] CMD_HRD   = 2'd2;
	localparam logic [1:0] CMD_NOP   = 2'd3;

	localparam logic [3:0] ST_OK     = 4'd0;
	localparam logic [3:0] ST_HALT   = 4'd1;
	localparam logic [3:0] ST_PTR1   = 4'd2;
	localparam logic [3:0] ST_PTR2   = 4'd3;
	localparam logic [3:0] ST_REG1   = 4'd4;
	localparam logic [3:0] ST_REG2   = 4'd5;
	localparam logic [3:0] ST_ADDR   = 4'd6;
	localparam logic [3:0] ST_BADOP  = 4'd7;
	localparam logic [3:0] ST_MODZ   = 4'd8;

	localparam logic [0:0] CFG_BASE  = 1'd0;
	localparam logic [0:0] CFG_LIMIT = 1'd1;

	localparam logic [7:0] CH_P = 8'h50;
	localparam logic [7:0] CH_R = 8'h52;
	localparam logic [7:0] CH_0 = 8'h30;

	localparam logic [6:0] OP_PSET = 7'd0;
	localparam logic [6:0] OP_PADD = 7'd1;
	localparam logic [6:0] OP_PSUB = 7'd2;
	localparam logic [6:0] OP_LDI  = 7'd3;
	localparam logic [6:0] OP_LDP  = 7'd4;
	localparam logic [6:0] OP_LDD  = 7'd5;
	localparam logic [6:0] OP_STP  = 7'd6;
	localparam logic [6:0] OP_STD  = 7'd7;
	localparam logic [6:0] OP_RSTP = 7'd8;
	localparam logic [6:0] OP_RSTD = 7'd9;
	localparam logic [6:0] OP_RLDP = 7'd10;
	localparam logic [6:0] OP_RLDD = 7'd11;
	localparam logic [6:0] OP_R0I  = 7'd12;
	localparam logic [6:0] OP_RMOV = 7'd13;
	localparam logic [6:0] OP_RTOA = 7'd14;
	localparam logic [6:0] OP_ATOR = 7'd15;
	localparam logic [6:0] OP_ADDI = 7'd16;
	localparam logic [6:0] OP_SUBI = 7'd17;
	localparam logic [6:0] OP_ADDR = 7'd18;
	localparam logic [6:0] OP_SUBR = 7'd19;
	localparam logic [6:0] OP_ADDP = 7'd20;
	localparam logic [6:0] OP_ADDD = 7'd21;
	localparam logic [6:0] OP_SUBP = 7'd22;
	localparam logic [6:0] OP_SUBD = 7'd23;
	localparam logic [6:0] OP_CEQP = 7'd24;
	localparam logic [6:0] OP_CLTP = 7'd25;
	localparam logic [6:0] OP_CGTP = 7'd26;
	localparam logic [6:0] OP_CGTI = 7'd27;
	localparam logic [6:0] OP_CEQI = 7'd28;
	localparam logic [6:0] OP_CLTI = 7'd29;
	localparam logic [6:0] OP_CEQR = 7'd30;
	localparam logic [6:0] OP_CLTR = 7'd31;
	localparam logic [6:0] OP_CGTR = 7'd32;
	localparam logic [6:0] OP_BT   = 7'd33;
	localparam logic [6:0] OP_BF   = 7'd34;
	localparam logic [6:0] OP_BR   = 7'd35;
	localparam logic [6:0] OP_TRAP = 7'd36;
	localparam logic [6:0] OP_MOD  = 7'd37;
	localparam logic [6:0] OP_HALT = 7'd99;

	// address operand source
	localparam logic [1:0] AS_NONE = 2'd0;
	localparam logic [1:0] AS_PTR  = 2'd1;
	localparam logic [1:0] AS_DIR  = 2'd2;

	// decoded instruction, front to back
	typedef struct packed {
		logic [1:0]  cmd;
		logic [6:0]  opcode;
		logic [3:0]  status;
		logic [1:0]  asrc;
		logic [1:0]  pidx;
		logic [1:0]  g1;
		logic [1:0]  g2;
		logic [6:0]  o1;
		logic [6:0]  o2;
		logic [13:0] imm;
		logic [3:0]  dd;
		logic [9:0]  host_address;
		logic [13:0] host_data;
	} dec_t;

	function automatic logic [3:0] dig(input logic [7:0] c);
		logic [7:0] t;
		t = c - CH_0;
		return (c >= CH_0 && t <= 8'd9) ? t[3:0] : 4'd0;
	endfunction

endpackage

/* rtl/dacc_front.sv */
module dacc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  dacc_pkg::in_item_t   in_data,
	output logic                 q_valid,
	input  logic                 q_take,
	output dacc_pkg::dec_t       q_data
);
	localparam int QD = 2;

	dacc_pkg::dec_t  d;
	dacc_pkg::dec_t  mem_q [QD];
	logic            wp_q, rp_q;
	logic [1:0]      cnt_q;
	logic [3:0]      da, db, dc, dd;
	logic            p1ok, p2ok, g1ok, g2ok;
	logic [6:0]      o1, o2;
	logic [6:0]      op;
	logic            push;

	always_comb begin
		da = dacc_pkg::dig(in_data.operand_char_a);
		db = dacc_pkg::dig(in_data.operand_char_b);
		dc = dacc_pkg::dig(in_data.operand_char_c);
		dd = dacc_pkg::dig(in_data.operand_char_d);
		o1 = 7'({3'd0, da} * 7'd10 + {3'd0, db});
		o2 = 7'({3'd0, dc} * 7'd10 + {3'd0, dd});
		p1ok = in_data.operand_char_a == dacc_pkg::CH_P
			&& in_data.operand_char_b >= dacc_pkg::CH_0
			&& in_data.operand_char_b <= dacc_pkg::CH_0 + 8'd3;
		g1ok = in_data.operand_char_a == dacc_pkg::CH_R
			&& in_data.operand_char_b >= dacc_pkg::CH_0
			&& in_data.operand_char_b <= dacc_pkg::CH_0 + 8'd3;
		p2ok = in_data.operand_char_c == dacc_pkg::CH_P
			&& in_data.operand_char_d >= dacc_pkg::CH_0
			&& in_data.operand_char_d <= dacc_pkg::CH_0 + 8'd3;
		g2ok = in_data.operand_char_c == dacc_pkg::CH_R
			&& in_data.operand_char_d >= dacc_pkg::CH_0
			&& in_data.operand_char_d <= dacc_pkg::CH_0 + 8'd3;
		op = in_data.opcode;
		d = '0;
		d.cmd = in_data.cmd;
		d.opcode = op;
		d.o1 = o1;
		d.o2 = o2;
		d.imm = 14'({7'd0, o1} * 14'd100 + {7'd0, o2});
		d.dd = dd;
		d.g1 = in_data.operand_char_b[1:0];
		d.g2 = in_data.operand_char_d[1:0];
		d.host_address = in_data.host_address;
		d.host_data = in_data.host_data;
		d.status = dacc_pkg::ST_OK;
		d.asrc = dacc_pkg::AS_NONE;
		d.pidx = in_data.operand_char_b[1:0];
		if (in_data.cmd == dacc_pkg::CMD_EXEC) begin
			unique case (op)
				dacc_pkg::OP_PSET, dacc_pkg::OP_PADD, dacc_pkg::OP_PSUB,
				dacc_pkg::OP_LDP, dacc_pkg::OP_STP, dacc_pkg::OP_ADDP,
				dacc_pkg::OP_SUBP, dacc_pkg::OP_CEQP, dacc_pkg::OP_CLTP,
				dacc_pkg::OP_CGTP: begin
					if (!p1ok) d.status = dacc_pkg::ST_PTR1;
					else if (op != dacc_pkg::OP_PSET && op != dacc_pkg::OP_PADD
							&& op != dacc_pkg::OP_PSUB)
						d.asrc = dacc_pkg::AS_PTR;
				end
				dacc_pkg::OP_LDD, dacc_pkg::OP_STD, dacc_pkg::OP_ADDD,
				dacc_pkg::OP_SUBD: d.asrc = dacc_pkg::AS_DIR;
				dacc_pkg::OP_LDI, dacc_pkg::OP_R0I, dacc_pkg::OP_ADDI,
				dacc_pkg::OP_SUBI, dacc_pkg::OP_CGTI, dacc_pkg::OP_CEQI,
				dacc_pkg::OP_CLTI, dacc_pkg::OP_BT, dacc_pkg::OP_BF,
				dacc_pkg::OP_BR: ;
				dacc_pkg::OP_HALT: d.status = dacc_pkg::ST_HALT;
				dacc_pkg::OP_RSTP, dacc_pkg::OP_RSTD, dacc_pkg::OP_RLDP,
				dacc_pkg::OP_RLDD, dacc_pkg::OP_RMOV, dacc_pkg::OP_RTOA,
				dacc_pkg::OP_ATOR, dacc_pkg::OP_ADDR, dacc_pkg::OP_SUBR,
				dacc_pkg::OP_CEQR, dacc_pkg::OP_CLTR, dacc_pkg::OP_CGTR,
				dacc_pkg::OP_TRAP, dacc_pkg::OP_MOD: begin
					if (!g1ok) d.status = dacc_pkg::ST_REG1;
					else if (op == dacc_pkg::OP_RSTP || op == dacc_pkg::OP_RLDP) begin
						d.pidx = in_data.operand_char_d[1:0];
						if (!p2ok) d.status = dacc_pkg::ST_PTR2;
						else d.asrc = dacc_pkg::AS_PTR;
					end else if (op == dacc_pkg::OP_RSTD || op == dacc_pkg::OP_RLDD) begin
						d.asrc = dacc_pkg::AS_DIR;
					end else if ((op == dacc_pkg::OP_RMOV || op == dacc_pkg::OP_MOD)
							&& !g2ok)
						d.status = dacc_pkg::ST_REG2;
				end
				default: d.status = dacc_pkg::ST_BADOP;
			endcase
		end
	end

	assign in_stall = cnt_q == 2'(QD);
	assign push = in_valid && !in_stall;
	assign q_valid = cnt_q != 2'd0;
	assign q_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_take) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_take);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'(QD))
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) q_take |-> q_valid)
		else $error("take from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !q_take) |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("queue count lost");
endmodule

/* rtl/dacc_back.sv */
module dacc_back #(
	parameter int MEM_WORDS = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [9:0]           base_q,
	input  logic [9:0]           limit_q,
	input  logic                 q_valid,
	output logic                 q_take,
	input  dacc_pkg::dec_t       q_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output dacc_pkg::out_item_t  out_data
);
	localparam int AW = $clog2(MEM_WORDS);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ADDR = 3'd1;
	localparam logic [2:0] S_MEM  = 3'd2;
	localparam logic [2:0] S_EXE  = 3'd3;
	localparam logic [2:0] S_MOD  = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0]       state_q;
	dacc_pkg::dec_t   i_q;
	logic [13:0]      acc_q;
	logic [13:0]      gr_q [4];
	logic [6:0]       pr_q [4];
	logic [6:0]       pc_q;
	logic             cf_q;
	logic [13:0]      mem [MEM_WORDS];
	logic [13:0]      rdata_q;
	logic [AW-1:0]    ea_q;
	logic             eaok_q;
	logic             viol_q;
	logic [3:0]       st_q;
	logic [13:0]      rd_q;
	logic             trap_q;
	logic [13:0]      tnum_q;
	logic [3:0]       top_q;
	logic [13:0]      rem_q, dvs_q;
	logic [4:0]       mcnt_q;
	logic [27:0]      dv_q;
	logic             busy_out_q;

	logic [12:0]      rel;
	logic [12:0]      eas;
	logic             eaok;
	logic             dirbad;
	logic [14:0]      sum_w;
	logic [14:0]      dif_w;
	logic [7:0]       padd_w;
	logic [7:0]       psub_w;
	logic [13:0]      opnd;
	logic             is_wr;
	logic             mw_en;
	logic [AW-1:0]    mw_addr;
	logic [13:0]      mw_data;
	logic [14:0]      trial;

	assign q_take = q_valid && state_q == S_IDLE && !busy_out_q;
	assign out_valid = busy_out_q;

	always_comb begin
		rel = (i_q.asrc == dacc_pkg::AS_PTR) ? 13'(pr_q[i_q.pidx])
			: ((i_q.opcode == dacc_pkg::OP_RSTD || i_q.opcode == dacc_pkg::OP_RLDD)
				? 13'(i_q.o2) : 13'(i_q.o1));
		dirbad = i_q.asrc == dacc_pkg::AS_DIR && rel >= 13'(MEM_WORDS);
		eas = rel + 13'(base_q);
		eaok = eas <= 13'(limit_q) && eas < 13'(MEM_WORDS);
		is_wr = i_q.opcode == dacc_pkg::OP_STP || i_q.opcode == dacc_pkg::OP_STD
			|| i_q.opcode == dacc_pkg::OP_RSTP || i_q.opcode == dacc_pkg::OP_RSTD;
	end

	always_comb begin
		unique case (i_q.opcode)
			dacc_pkg::OP_LDI, dacc_pkg::OP_ADDI, dacc_pkg::OP_SUBI, dacc_pkg::OP_CGTI,
			dacc_pkg::OP_CEQI, dacc_pkg::OP_CLTI: opnd = i_q.imm;
			dacc_pkg::OP_ADDR, dacc_pkg::OP_SUBR, dacc_pkg::OP_CEQR, dacc_pkg::OP_CLTR,
			dacc_pkg::OP_CGTR: opnd = gr_q[i_q.g1];
			default: opnd = rdata_q;
		endcase
		sum_w = 15'(acc_q) + 15'(opnd);
		if (sum_w >= 15'd10000) sum_w = sum_w - 15'd10000;
		dif_w = 15'(acc_q) + 15'd10000 - 15'(opnd);
		if (dif_w >= 15'd10000) dif_w = dif_w - 15'd10000;
		padd_w = 8'(pr_q[i_q.pidx]) + 8'(i_q.o2);
		if (padd_w >= 8'd100) padd_w = padd_w - 8'd100;
		psub_w = 8'(pr_q[i_q.pidx]) + 8'd100 - 8'(i_q.o2);
		if (psub_w >= 8'd100) psub_w = psub_w - 8'd100;
		trial = {rem_q, dv_q[27]} - {1'b0, dvs_q};
	end

	always_comb begin
		mw_en = 1'b0;
		mw_addr = AW'(i_q.host_address);
		mw_data = i_q.host_data > 14'd9999 ? 14'd9999 : i_q.host_data;
		if (state_q == S_ADDR && i_q.cmd == dacc_pkg::CMD_HWR
				&& 32'(i_q.host_address) < MEM_WORDS)
			mw_en = 1'b1;
		if (state_q == S_MEM && i_q.cmd == dacc_pkg::CMD_EXEC && eaok_q && is_wr) begin
			mw_en = 1'b1;
			mw_addr = ea_q;
			mw_data = (i_q.opcode == dacc_pkg::OP_RSTP || i_q.opcode == dacc_pkg::OP_RSTD)
				? gr_q[i_q.g1] : acc_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mw_en) mem[mw_addr] <= mw_data;
		if (state_q == S_ADDR) begin
			if (i_q.cmd == dacc_pkg::CMD_EXEC) rdata_q <= mem[eas[AW-1:0]];
			else rdata_q <= mem[AW'(i_q.host_address)];
		end
	end

	always_ff @(posedge clk) begin
		if (q_take) i_q <= q_data;
		if (state_q == S_ADDR) begin
			ea_q <= eas[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_out_q <= 1'b0;
			acc_q <= '0;
			for (int k = 0; k < 4; k++) begin
				gr_q[k] <= '0;
				pr_q[k] <= '0;
			end
			pc_q <= '0;
			cf_q <= 1'b1;
			eaok_q <= 1'b0;
			viol_q <= 1'b0;
			st_q <= '0;
			rd_q <= '0;
			trap_q <= 1'b0;
			tnum_q <= '0;
			top_q <= '0;
			rem_q <= '0;
			dvs_q <= '0;
			dv_q <= '0;
			mcnt_q <= '0;
		end else begin
			if (busy_out_q && !out_stall) busy_out_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (q_take) state_q <= S_ADDR;
				S_ADDR: begin
					st_q <= i_q.status;
					viol_q <= 1'b0;
					rd_q <= '0;
					trap_q <= 1'b0;
					tnum_q <= '0;
					top_q <= '0;
					eaok_q <= 1'b0;
					state_q <= S_OUT;
					if (i_q.cmd == dacc_pkg::CMD_HRD) state_q <= S_MEM;
					else if (i_q.cmd == dacc_pkg::CMD_EXEC) begin
						if (i_q.opcode != dacc_pkg::OP_HALT)
							pc_q <= (pc_q == 7'd99) ? 7'd0 : pc_q + 7'd1;
						if (i_q.status != dacc_pkg::ST_OK) state_q <= S_OUT;
						else if (dirbad) begin
							st_q <= dacc_pkg::ST_ADDR;
						end else if (i_q.asrc != dacc_pkg::AS_NONE) begin
							eaok_q <= eaok;
							viol_q <= !eaok;
							state_q <= S_MEM;
						end else state_q <= S_EXE;
					end
				end
				S_MEM: begin
					if (i_q.cmd == dacc_pkg::CMD_HRD) begin
						if (32'(i_q.host_address) < MEM_WORDS) rd_q <= rdata_q;
						state_q <= S_OUT;
					end else if (!eaok_q || is_wr) state_q <= S_OUT;
					else state_q <= S_EXE;
				end
				S_EXE: begin
					state_q <= S_OUT;
					unique case (i_q.opcode)
						dacc_pkg::OP_PSET: pr_q[i_q.pidx] <= i_q.o2;
						dacc_pkg::OP_PADD: pr_q[i_q.pidx] <= padd_w[6:0];
						dacc_pkg::OP_PSUB: pr_q[i_q.pidx] <= psub_w[6:0];
						dacc_pkg::OP_LDI: acc_q <= i_q.imm;
						dacc_pkg::OP_LDP, dacc_pkg::OP_LDD: acc_q <= rdata_q;
						dacc_pkg::OP_RLDP, dacc_pkg::OP_RLDD: gr_q[i_q.g1] <= rdata_q;
						dacc_pkg::OP_R0I: gr_q[0] <= i_q.imm;
						dacc_pkg::OP_RMOV: gr_q[i_q.g1] <= gr_q[i_q.g2];
						dacc_pkg::OP_RTOA: acc_q <= gr_q[i_q.g1];
						dacc_pkg::OP_ATOR: gr_q[i_q.g1] <= acc_q;
						dacc_pkg::OP_ADDI, dacc_pkg::OP_ADDR, dacc_pkg::OP_ADDP,
						dacc_pkg::OP_ADDD: acc_q <= sum_w[13:0];
						dacc_pkg::OP_SUBI, dacc_pkg::OP_SUBR, dacc_pkg::OP_SUBP,
						dacc_pkg::OP_SUBD: acc_q <= dif_w[13:0];
						dacc_pkg::OP_CEQP, dacc_pkg::OP_CEQI, dacc_pkg::OP_CEQR:
							cf_q <= acc_q == opnd;
						dacc_pkg::OP_CLTP, dacc_pkg::OP_CLTI, dacc_pkg::OP_CLTR:
							cf_q <= acc_q < opnd;
						dacc_pkg::OP_CGTP, dacc_pkg::OP_CGTI, dacc_pkg::OP_CGTR:
							cf_q <= acc_q > opnd;
						dacc_pkg::OP_BT: if (cf_q) pc_q <= i_q.o1;
						dacc_pkg::OP_BF: if (!cf_q) pc_q <= i_q.o1;
						dacc_pkg::OP_BR: pc_q <= i_q.o1;
						dacc_pkg::OP_TRAP: begin
							trap_q <= 1'b1;
							tnum_q <= gr_q[i_q.g1];
							top_q <= i_q.dd;
						end
						dacc_pkg::OP_MOD: begin
							if (gr_q[i_q.g2] == 14'd0) st_q <= dacc_pkg::ST_MODZ;
							else begin
								rem_q <= '0;
								dvs_q <= gr_q[i_q.g2];
								dv_q <= {gr_q[i_q.g1], 14'd0};
								mcnt_q <= 5'd14;
								state_q <= S_MOD;
							end
						end
						default: ;
					endcase
				end
				S_MOD: begin
					// restoring remainder, one bit per cycle
					if (!trial[14]) rem_q <= trial[13:0];
					else rem_q <= {rem_q[12:0], dv_q[27]};
					dv_q <= {dv_q[26:0], 1'b0};
					mcnt_q <= mcnt_q - 5'd1;
					if (mcnt_q == 5'd0) begin
						acc_q <= rem_q;
						state_q <= S_OUT;
					end
				end
				S_OUT: if (!busy_out_q || !out_stall) begin
					busy_out_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_data.status = st_q;
	assign out_data.program_counter = pc_q;
	assign out_data.accumulator = acc_q;
	assign out_data.compare_true = cf_q;
	assign out_data.range_violation = viol_q;
	assign out_data.read_word = rd_q;
	assign out_data.trap_raised = trap_q;
	assign out_data.trap_number = tnum_q;
	assign out_data.trap_operation = top_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result dropped under stall");
	assert property (@(posedge clk) disable iff (!arst_n) pc_q <= 7'd99)
		else $error("pc out of range");
	assert property (@(posedge clk) disable iff (!arst_n) q_take |=> state_q == S_ADDR)
		else $error("take without start");
	assert property (@(posedge clk) disable iff (!arst_n) mw_en |-> 32'(mw_addr) < MEM_WORDS)
		else $error("write beyond memory");
endmodule

/* rtl/decimal_accumulator_cpu_execute.sv */
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | in_data  (dacc_pkg::in_item_t)
// out     | out_valid | out_stall | out_data (dacc_pkg::out_item_t)
// cfg     | cfg_we    | -         | cfg_index, cfg_data
// Host writes, command 3 and failed instructions run S_ADDR, S_OUT; host reads
// add S_MEM, register/immediate instructions S_EXE, memory instructions S_MEM
// (then S_EXE for loads, adds, subtracts, compares), set by the back end
// sequencer and the single memory port. Modulo adds the bit-serial S_MOD loop.
// Reset clears registers, pc, the queue and the compare flag (set true).
// A two-entry queue lets the front accept while the back waits on out_stall.
module decimal_accumulator_cpu_execute #(
	parameter int MEM_WORDS = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  dacc_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output dacc_pkg::out_item_t  out_data,
	input  logic                 cfg_we,
	input  logic [0:0]           cfg_index,
	input  logic [9:0]           cfg_data
);
	logic [9:0]      base_q, limit_q;
	logic            q_valid, q_take;
	dacc_pkg::dec_t  q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			limit_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dacc_pkg::CFG_BASE:  base_q <= cfg_data;
				dacc_pkg::CFG_LIMIT: limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	dacc_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.q_valid(q_valid), .q_take(q_take), .q_data(q_data)
	);

	dacc_back #(.MEM_WORDS(MEM_WORDS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.base_q(base_q), .limit_q(limit_q),
		.q_valid(q_valid), .q_take(q_take), .q_data(q_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);
endmodule

/* sim/dacc_ops_pkg.sv */
package dacc_ops_pkg;

	localparam logic [6:0] OP_PSET = 7'd0;
	localparam logic [6:0] OP_PADD = 7'd1;
	localparam logic [6:0] OP_PSUB = 7'd2;
	localparam logic [6:0] OP_LDI  = 7'd3;
	localparam logic [6:0] OP_LDP  = 7'd4;
	localparam logic [6:0] OP_LDD  = 7'd5;
	localparam logic [6:0] OP_STP  = 7'd6;
	localparam logic [6:0] OP_STD  = 7'd7;
	localparam logic [6:0] OP_RSTP = 7'd8;
	localparam logic [6:0] OP_RSTD = 7'd9;
	localparam logic [6:0] OP_RLDP = 7'd10;
	localparam logic [6:0] OP_RLDD = 7'd11;
	localparam logic [6:0] OP_R0I  = 7'd12;
	localparam logic [6:0] OP_RMOV = 7'd13;
	localparam logic [6:0] OP_RTOA = 7'd14;
	localparam logic [6:0] OP_ATOR = 7'd15;
	localparam logic [6:0] OP_ADDI = 7'd16;
	localparam logic [6:0] OP_SUBI = 7'd17;
	localparam logic [6:0] OP_ADDR = 7'd18;
	localparam logic [6:0] OP_SUBR = 7'd19;
	localparam logic [6:0] OP_ADDP = 7'd20;
	localparam logic [6:0] OP_ADDD = 7'd21;
	localparam logic [6:0] OP_SUBP = 7'd22;
	localparam logic [6:0] OP_SUBD = 7'd23;
	localparam logic [6:0] OP_CEQP = 7'd24;
	localparam logic [6:0] OP_CLTP = 7'd25;
	localparam logic [6:0] OP_CGTP = 7'd26;
	localparam logic [6:0] OP_CGTI = 7'd27;
	localparam logic [6:0] OP_CEQI = 7'd28;
	localparam logic [6:0] OP_CLTI = 7'd29;
	localparam logic [6:0] OP_CEQR = 7'd30;
	localparam logic [6:0] OP_CLTR = 7'd31;
	localparam logic [6:0] OP_CGTR = 7'd32;
	localparam logic [6:0] OP_BT   = 7'd33;
	localparam logic [6:0] OP_BF   = 7'd34;
	localparam logic [6:0] OP_BR   = 7'd35;
	localparam logic [6:0] OP_TRAP = 7'd36;
	localparam logic [6:0] OP_MOD  = 7'd37;
	localparam logic [6:0] OP_HALT = 7'd99;

endpackage

/* sim/decimal_accumulator_cpu_execute_checker.sv */
module decimal_accumulator_cpu_execute_checker #(
	parameter int MEM_WORDS = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  dacc_pkg::in_item_t  in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  dacc_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  logic [9:0]          cfg_data,
	output int                  fail_count,
	output int                  pending,
	output int                  item_count,
	output int                  result_count
);
	int base_q, limit_q;
	int acc_q, pc_q;
	int greg_q [4];
	int preg_q [4];
	bit cflag_q;
	int mem_q [MEM_WORDS];
	dacc_pkg::out_item_t expected_results [$];

	function automatic int char_digit(input logic [7:0] c);
		return (c >= dacc_pkg::CH_0 && c <= dacc_pkg::CH_0 + 8'd9)
			? int'(c - dacc_pkg::CH_0) : 0;
	endfunction

	function automatic int reg_sel(input logic [7:0] s, input logic [7:0] n,
			input logic [7:0] kind);
		if (s != kind || n < dacc_pkg::CH_0 || n > dacc_pkg::CH_0 + 8'd3)
			return -1;
		return int'(n - dacc_pkg::CH_0);
	endfunction

	// effective address or -1 when outside base..limit or beyond memory
	function automatic int eff_addr(input int rel);
		int e;
		e = base_q + rel;
		if (e > limit_q || e >= MEM_WORDS)
			return -1;
		return e;
	endfunction

	task automatic exec_step(input dacc_pkg::in_item_t it, output dacc_pkg::out_item_t r);
		int o1, o2, imm, p1, p2, g1, g2, ea, v;
		logic [3:0] st;
		bit viol, trap;
		int rd, tnum, topd;
		o1 = char_digit(it.operand_char_a) * 10 + char_digit(it.operand_char_b);
		o2 = char_digit(it.operand_char_c) * 10 + char_digit(it.operand_char_d);
		imm = o1 * 100 + o2;
		p1 = reg_sel(it.operand_char_a, it.operand_char_b, dacc_pkg::CH_P);
		p2 = reg_sel(it.operand_char_c, it.operand_char_d, dacc_pkg::CH_P);
		g1 = reg_sel(it.operand_char_a, it.operand_char_b, dacc_pkg::CH_R);
		g2 = reg_sel(it.operand_char_c, it.operand_char_d, dacc_pkg::CH_R);
		st = dacc_pkg::ST_OK;
		viol = 0;
		trap = 0;
		rd = 0;
		tnum = 0;
		topd = 0;
		ea = -1;
		if (it.cmd == dacc_pkg::CMD_HWR) begin
			if (it.host_address < MEM_WORDS)
				mem_q[it.host_address] = it.host_data > 9999 ? 9999 : it.host_data;
		end else if (it.cmd == dacc_pkg::CMD_HRD) begin
			if (it.host_address < MEM_WORDS)
				rd = mem_q[it.host_address];
		end else if (it.cmd == dacc_pkg::CMD_EXEC) begin
			if (it.opcode != dacc_ops_pkg::OP_HALT)
				pc_q = (pc_q + 1) % 100;
			case (it.opcode)
				dacc_ops_pkg::OP_PSET, dacc_ops_pkg::OP_PADD, dacc_ops_pkg::OP_PSUB,
				dacc_ops_pkg::OP_LDP, dacc_ops_pkg::OP_STP, dacc_ops_pkg::OP_ADDP,
				dacc_ops_pkg::OP_SUBP, dacc_ops_pkg::OP_CEQP, dacc_ops_pkg::OP_CLTP,
				dacc_ops_pkg::OP_CGTP: begin
					if (p1 < 0)
						st = dacc_pkg::ST_PTR1;
					else if (it.opcode == dacc_ops_pkg::OP_PSET)
						preg_q[p1] = o2;
					else if (it.opcode == dacc_ops_pkg::OP_PADD)
						preg_q[p1] = (preg_q[p1] + o2) % 100;
					else if (it.opcode == dacc_ops_pkg::OP_PSUB)
						preg_q[p1] = (preg_q[p1] + 100 - o2) % 100;
					else begin
						ea = eff_addr(preg_q[p1]);
						viol = ea < 0;
						if (!viol) begin
							v = mem_q[ea];
							case (it.opcode)
								dacc_ops_pkg::OP_STP: mem_q[ea] = acc_q;
								dacc_ops_pkg::OP_LDP: acc_q = v;
								dacc_ops_pkg::OP_ADDP: acc_q = (acc_q + v) % 10000;
								dacc_ops_pkg::OP_SUBP: acc_q = (acc_q + 10000 - v) % 10000;
								dacc_ops_pkg::OP_CEQP: cflag_q = acc_q == v;
								dacc_ops_pkg::OP_CLTP: cflag_q = acc_q < v;
								default: cflag_q = acc_q > v;
							endcase
						end
					end
				end
				dacc_ops_pkg::OP_LDD, dacc_ops_pkg::OP_STD, dacc_ops_pkg::OP_ADDD,
				dacc_ops_pkg::OP_SUBD: begin
					if (o1 >= MEM_WORDS)
						st = dacc_pkg::ST_ADDR;
					else begin
						ea = eff_addr(o1);
						viol = ea < 0;
						if (!viol) begin
							v = mem_q[ea];
							case (it.opcode)
								dacc_ops_pkg::OP_STD: mem_q[ea] = acc_q;
								dacc_ops_pkg::OP_LDD: acc_q = v;
								dacc_ops_pkg::OP_ADDD: acc_q = (acc_q + v) % 10000;
								default: acc_q = (acc_q + 10000 - v) % 10000;
							endcase
						end
					end
				end
				dacc_ops_pkg::OP_LDI: acc_q = imm;
				dacc_ops_pkg::OP_R0I: greg_q[0] = imm;
				dacc_ops_pkg::OP_ADDI: acc_q = (acc_q + imm) % 10000;
				dacc_ops_pkg::OP_SUBI: acc_q = (acc_q + 10000 - imm) % 10000;
				dacc_ops_pkg::OP_CGTI: cflag_q = acc_q > imm;
				dacc_ops_pkg::OP_CEQI: cflag_q = acc_q == imm;
				dacc_ops_pkg::OP_CLTI: cflag_q = acc_q < imm;
				dacc_ops_pkg::OP_BT: if (cflag_q) pc_q = o1;
				dacc_ops_pkg::OP_BF: if (!cflag_q) pc_q = o1;
				dacc_ops_pkg::OP_BR: pc_q = o1;
				dacc_ops_pkg::OP_HALT: st = dacc_pkg::ST_HALT;
				dacc_ops_pkg::OP_RSTP, dacc_ops_pkg::OP_RSTD, dacc_ops_pkg::OP_RLDP,
				dacc_ops_pkg::OP_RLDD, dacc_ops_pkg::OP_RMOV, dacc_ops_pkg::OP_RTOA,
				dacc_ops_pkg::OP_ATOR, dacc_ops_pkg::OP_ADDR, dacc_ops_pkg::OP_SUBR,
				dacc_ops_pkg::OP_CEQR, dacc_ops_pkg::OP_CLTR, dacc_ops_pkg::OP_CGTR,
				dacc_ops_pkg::OP_TRAP, dacc_ops_pkg::OP_MOD: begin
					if (g1 < 0)
						st = dacc_pkg::ST_REG1;
					else if (it.opcode == dacc_ops_pkg::OP_RSTP
							|| it.opcode == dacc_ops_pkg::OP_RLDP) begin
						if (p2 < 0)
							st = dacc_pkg::ST_PTR2;
						else begin
							ea = eff_addr(preg_q[p2]);
							viol = ea < 0;
							if (!viol && it.opcode == dacc_ops_pkg::OP_RSTP)
								mem_q[ea] = greg_q[g1];
							else if (!viol)
								greg_q[g1] = mem_q[ea];
						end
					end else if (it.opcode == dacc_ops_pkg::OP_RSTD
							|| it.opcode == dacc_ops_pkg::OP_RLDD) begin
						if (o2 >= MEM_WORDS)
							st = dacc_pkg::ST_ADDR;
						else begin
							ea = eff_addr(o2);
							viol = ea < 0;
							if (!viol && it.opcode == dacc_ops_pkg::OP_RSTD)
								mem_q[ea] = greg_q[g1];
							else if (!viol)
								greg_q[g1] = mem_q[ea];
						end
					end else if (it.opcode == dacc_ops_pkg::OP_RMOV
							|| it.opcode == dacc_ops_pkg::OP_MOD) begin
						if (g2 < 0)
							st = dacc_pkg::ST_REG2;
						else if (it.opcode == dacc_ops_pkg::OP_RMOV)
							greg_q[g1] = greg_q[g2];
						else if (greg_q[g2] == 0)
							st = dacc_pkg::ST_MODZ;
						else
							acc_q = greg_q[g1] % greg_q[g2];
					end else begin
						case (it.opcode)
							dacc_ops_pkg::OP_RTOA: acc_q = greg_q[g1];
							dacc_ops_pkg::OP_ATOR: greg_q[g1] = acc_q;
							dacc_ops_pkg::OP_ADDR: acc_q = (acc_q + greg_q[g1]) % 10000;
							dacc_ops_pkg::OP_SUBR:
								acc_q = (acc_q + 10000 - greg_q[g1]) % 10000;
							dacc_ops_pkg::OP_CEQR: cflag_q = acc_q == greg_q[g1];
							dacc_ops_pkg::OP_CLTR: cflag_q = acc_q < greg_q[g1];
							dacc_ops_pkg::OP_CGTR: cflag_q = acc_q > greg_q[g1];
							default: begin
								trap = 1;
								tnum = greg_q[g1];
								topd = char_digit(it.operand_char_d);
							end
						endcase
					end
				end
				default: st = dacc_pkg::ST_BADOP;
			endcase
		end
		r.status = st;
		r.program_counter = 7'(pc_q);
		r.accumulator = 14'(acc_q);
		r.compare_true = cflag_q;
		r.range_violation = viol;
		r.read_word = 14'(rd);
		r.trap_raised = trap;
		r.trap_number = 14'(tnum);
		r.trap_operation = 4'(topd);
	endtask

	task automatic cmp_field(input string nm, input int e, input int a);
		if (e != a) begin
			fail_count++;
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, nm, e, a);
		end
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
		item_count = 0;
		result_count = 0;
		base_q = 0;
		limit_q = 0;
		acc_q = 0;
		pc_q = 0;
		cflag_q = 1;
		for (int i = 0; i < 4; i++) begin
			greg_q[i] = 0;
			preg_q[i] = 0;
		end
		for (int i = 0; i < MEM_WORDS; i++)
			mem_q[i] = 0;
	end

	always @(posedge clk) begin
		dacc_pkg::out_item_t r, e;
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == dacc_pkg::CFG_BASE)
					base_q = cfg_data;
				else
					limit_q = cfg_data;
			end
			if (in_valid && !in_stall) begin
				exec_step(in_data, r);
				expected_results.push_back(r);
				item_count++;
			end
			if (out_valid && !out_stall) begin
				result_count++;
				if (expected_results.size() == 0) begin
					fail_count++;
					$display("%0t: result with nothing expected, actual %p", $time, out_data);
				end else begin
					e = expected_results.pop_front();
					cmp_field("status", e.status, out_data.status);
					cmp_field("program_counter", e.program_counter,
						out_data.program_counter);
					cmp_field("accumulator", e.accumulator, out_data.accumulator);
					cmp_field("compare_true", e.compare_true, out_data.compare_true);
					cmp_field("range_violation", e.range_violation,
						out_data.range_violation);
					cmp_field("read_word", e.read_word, out_data.read_word);
					cmp_field("trap_raised", e.trap_raised, out_data.trap_raised);
					cmp_field("trap_number", e.trap_number, out_data.trap_number);
					cmp_field("trap_operation", e.trap_operation,
						out_data.trap_operation);
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

/* sim/decimal_accumulator_cpu_execute_tb.sv */
module decimal_accumulator_cpu_execute_tb;
	localparam int MEM_WORDS = 1024;

	localparam logic [7:0] CH_0 = dacc_pkg::CH_0;
	localparam logic [7:0] CH_P = dacc_pkg::CH_P;
	localparam logic [7:0] CH_R = dacc_pkg::CH_R;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	dacc_pkg::in_item_t  in_data;
	logic                out_valid;
	logic                out_stall;
	dacc_pkg::out_item_t out_data;
	logic                cfg_we;
	logic [0:0]          cfg_index;
	logic [9:0]          cfg_data;

	int fail_count, pending, item_count, result_count;
	bit idle_on;
	bit long_hold_req;
	int burst_left;
	int hold_left;

	decimal_accumulator_cpu_execute #(.MEM_WORDS(MEM_WORDS)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	decimal_accumulator_cpu_execute_checker #(.MEM_WORDS(MEM_WORDS)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending),
		.item_count(item_count), .result_count(result_count)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("== FAIL ==");
		$finish;
	end

	// result side back-pressure
	initial begin
		out_stall = 0;
		burst_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 0;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1;
			end else if (burst_left > 0) begin
				burst_left--;
				out_stall <= 1;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				burst_left = $urandom_range(1, 13) - 1;
				out_stall <= 1;
			end else
				out_stall <= 0;
		end
	end

	function automatic logic [7:0] rand_char();
		int k;
		k = $urandom_range(0, 99);
		if (k < 15)
			return CH_P;
		if (k < 30)
			return CH_R;
		if (k < 88)
			return CH_0 + 8'($urandom_range(0, 9));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic dacc_pkg::in_item_t mk_exec(input logic [6:0] op,
			input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
			input logic [7:0] d);
		dacc_pkg::in_item_t it;
		it.cmd = dacc_pkg::CMD_EXEC;
		it.opcode = op;
		it.operand_char_a = a;
		it.operand_char_b = b;
		it.operand_char_c = c;
		it.operand_char_d = d;
		it.host_address = 10'($urandom);
		it.host_data = 14'($urandom);
		return it;
	endfunction

	function automatic dacc_pkg::in_item_t mk_host(input logic [1:0] cmd, input int addr,
			input int data);
		dacc_pkg::in_item_t it;
		it = mk_exec(dacc_ops_pkg::OP_HALT, 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom));
		it.cmd = cmd;
		it.host_address = 10'(addr);
		it.host_data = 14'(data);
		return it;
	endfunction

	function automatic dacc_pkg::in_item_t rand_instr();
		int k;
		logic [6:0] op;
		k = $urandom_range(0, 99);
		if (k < 6)
			return mk_host(dacc_pkg::CMD_HWR, $urandom_range(0, MEM_WORDS - 1),
				$urandom_range(0, 16383));
		if (k < 12)
			return mk_host(dacc_pkg::CMD_HRD, $urandom_range(0, MEM_WORDS - 1),
				$urandom_range(0, 16383));
		if (k < 14)
			return mk_host(dacc_pkg::CMD_NOP, $urandom_range(0, MEM_WORDS - 1),
				$urandom_range(0, 16383));
		k = $urandom_range(0, 99);
		if (k < 6)
			op = 7'($urandom);
		else begin
			k = $urandom_range(0, 38);
			op = (k == 38) ? dacc_ops_pkg::OP_HALT : 7'(k);
		end
		return mk_exec(op, rand_char(), rand_char(), rand_char(), rand_char());
	endfunction

	task automatic send(input dacc_pkg::in_item_t it);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1;
		in_data <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_window(input int base, input int limit);
		cfg_we <= 1;
		cfg_index <= dacc_pkg::CFG_BASE;
		cfg_data <= 10'(base);
		@(posedge clk);
		cfg_index <= dacc_pkg::CFG_LIMIT;
		cfg_data <= 10'(limit);
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	task automatic run_random(input int n, input bit with_hold);
		for (int i = 0; i < n; i++) begin
			if (with_hold && i == 20)
				long_hold_req = 1;
			send(rand_instr());
		end
	endtask

	localparam logic [7:0] CH_X = 8'h58;

	initial begin
		int bases [5];
		int limits [5];
		bases = '{0, 900, 1023, 0, 950};
		limits = '{1023, 950, 1023, 0, 1023};
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		cfg_we = 0;
		cfg_index = dacc_pkg::CFG_BASE;
		cfg_data = '0;
		idle_on = 1;
		long_hold_req = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		set_window(0, 1023);

		// every word gets a defined value before any read
		for (int a = 0; a < MEM_WORDS; a++)
			send(mk_host(dacc_pkg::CMD_HWR, a, ($urandom_range(0, 9) == 0) ?
				$urandom_range(10000, 16383) : $urandom_range(0, 9999)));

		send(mk_exec(dacc_ops_pkg::OP_LDI, CH_0 + 8'd9, CH_0 + 8'd9, CH_0 + 8'd9,
			CH_0 + 8'd9));
		send(mk_exec(dacc_ops_pkg::OP_ADDI, CH_0, CH_0, CH_0, CH_0 + 8'd2));
		send(mk_exec(dacc_ops_pkg::OP_SUBI, CH_0, CH_0, CH_0, CH_0 + 8'd5));
		send(mk_exec(dacc_ops_pkg::OP_LDI, CH_X, 8'hFF, 8'h00, CH_P));
		send(mk_exec(dacc_ops_pkg::OP_HALT, CH_0, CH_0, CH_0, CH_0));
		send(mk_exec(7'd50, CH_0, CH_0, CH_0, CH_0));
		send(mk_exec(7'd127, CH_R, CH_0, CH_R, CH_0));
		send(mk_exec(dacc_ops_pkg::OP_PSET, CH_P, CH_0, CH_0 + 8'd4, CH_0 + 8'd2));
		send(mk_exec(dacc_ops_pkg::OP_PSUB, CH_P, CH_0 + 8'd1, CH_0, CH_0 + 8'd1));
		send(mk_exec(dacc_ops_pkg::OP_PSET, CH_X, CH_0, CH_0, CH_0 + 8'd1));
		send(mk_exec(dacc_ops_pkg::OP_RSTP, CH_R, CH_0, CH_X, CH_0));
		send(mk_exec(dacc_ops_pkg::OP_RTOA, CH_R, CH_0 + 8'd7, CH_0, CH_0));
		send(mk_exec(dacc_ops_pkg::OP_MOD, CH_R, CH_0, CH_R, CH_0 + 8'd1));
		send(mk_exec(dacc_ops_pkg::OP_MOD, CH_R, CH_0, CH_X, CH_0 + 8'd1));
		send(mk_exec(dacc_ops_pkg::OP_R0I, CH_0 + 8'd1, CH_0 + 8'd2, CH_0 + 8'd3,
			CH_0 + 8'd4));
		send(mk_exec(dacc_ops_pkg::OP_LDI, CH_0, CH_0, CH_0, CH_0 + 8'd7));
		send(mk_exec(dacc_ops_pkg::OP_ATOR, CH_R, CH_0 + 8'd1, CH_0, CH_0));
		send(mk_exec(dacc_ops_pkg::OP_MOD, CH_R, CH_0, CH_R, CH_0 + 8'd1));
		send(mk_exec(dacc_ops_pkg::OP_TRAP, CH_R, CH_0, CH_X, CH_0 + 8'd5));
		send(mk_exec(dacc_ops_pkg::OP_ADDP, CH_P, CH_0, CH_0, CH_0));
		send(mk_exec(dacc_ops_pkg::OP_STD, CH_0 + 8'd9, CH_0 + 8'd9, CH_0, CH_0));
		send(mk_exec(dacc_ops_pkg::OP_LDD, CH_0 + 8'd9, CH_0 + 8'd9, CH_0, CH_0));
		send(mk_exec(dacc_ops_pkg::OP_BR, CH_0 + 8'd9, CH_0 + 8'd9, CH_0, CH_0));
		send(mk_exec(dacc_ops_pkg::OP_BT, CH_0 + 8'd1, CH_0, CH_0, CH_0));
		send(mk_host(dacc_pkg::CMD_NOP, 5, 0));
		send(mk_host(dacc_pkg::CMD_HWR, 5, 16383));
		send(mk_host(dacc_pkg::CMD_HRD, 5, 0));

		for (int ph = 0; ph < 5; ph++) begin
			drain();
			set_window(bases[ph], limits[ph]);
			if (ph == 4)
				idle_on = 0;
			run_random(100, ph == 1);
		end

		drain();
		if (pending != 0)
			$display("%0t: %0d results never arrived", $time, pending);
		$display("Covered %0d items and %0d results over 5 base/limit windows,",
			item_count, result_count);
		$display("with memory preload, directed corner cases, long stall and idle bursts.");
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* sim.f */
rtl/dacc_pkg.sv
rtl/dacc_front.sv
rtl/dacc_back.sv
rtl/decimal_accumulator_cpu_execute.sv
sim/dacc_ops_pkg.sv
sim/decimal_accumulator_cpu_execute_checker.sv
sim/decimal_accumulator_cpu_execute_tb.sv
